// ----- rtl/assert_macros.svh -----
// assertion helpers for the timer bank
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- rtl/swcb_pkg.sv -----
// ----------------------------------------------------------------------------
// swcb_pkg
// types and constants shared by the timer bank modules
// ----------------------------------------------------------------------------
package swcb_pkg;
  localparam int NUM_TIMERS_DEF = 64;
  localparam int TW = 40;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0, OP_PAUSE = 3'd1, OP_RESUME = 3'd2,
    OP_REMOVE = 3'd3, OP_CLEAR = 3'd4, OP_READ = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  localparam logic [1:0] MODE_UP     = 2'd0;
  localparam logic [1:0] MODE_DOWN   = 2'd1;
  localparam logic [1:0] MODE_PAUSED = 2'd2;

  localparam logic [TW-1:0] SEC_YEAR  = TW'(365 * 86400);
  localparam logic [TW-1:0] SEC_MONTH = TW'(30 * 86400);
  localparam logic [TW-1:0] SEC_DAY   = TW'(86400);
  localparam logic [TW-1:0] SEC_HOUR  = TW'(3600);

  // one queued request
  typedef struct packed {
    logic [2:0]    op;
    logic [5:0]    slot;
    logic [TW-1:0] now;
    logic          cd;
    logic [TW-1:0] tgt;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  mode;
    logic [15:0] years;
    logic [3:0]  months;
    logic [4:0]  days;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [6:0]  entry_count;
  } rsp_t;
endpackage

// ----- rtl/swcb_if.sv -----
// ----------------------------------------------------------------------------
// swcb_req_if / swcb_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface swcb_req_if;
  import swcb_pkg::*;
  logic          valid;
  logic          ready;
  logic [2:0]    operation;
  logic [5:0]    slot;
  logic [TW-1:0] now_seconds;
  logic          countdown;
  logic [TW-1:0] target_seconds;
  modport source (output valid, operation, slot, now_seconds, countdown,
                  target_seconds, input ready);
  modport sink (input valid, operation, slot, now_seconds, countdown,
                target_seconds, output ready);
endinterface

interface swcb_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  mode;
  logic [15:0] years;
  logic [3:0]  months;
  logic [4:0]  days;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [6:0]  entry_count;
  modport source (output valid, status, mode, years, months, days, hours,
                  minutes, seconds, entry_count, input ready);
  modport sink (input valid, status, mode, years, months, days, hours,
                minutes, seconds, entry_count, output ready);
endinterface

// ----- rtl/stopwatch_countdown_bank.sv -----
// ----------------------------------------------------------------------------
// stopwatch_countdown_bank
// bank of count-up and countdown timers driven by one request per item
// ----------------------------------------------------------------------------
// A request passes from acceptance to result through the sequencer states
// idle, fetch, execute and output; remove also passes through the shift
// state, which moves each later entry down one place, and a read that
// reports a time also passes through the split state for the time split
// (eleven radix-16 digits and the seconds). A stall on the result channel
// holds the result in the output state. The sequencer sits in the back end,
// whose entry memory has registered reads. A two-deep request queue lets
// requests arrive while one executes.
module stopwatch_countdown_bank
  import swcb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input logic clk,
  input logic rst,
  swcb_req_if.sink   req,
  swcb_rsp_if.source rsp
);
`include "assert_macros.svh"
  localparam int CW = $clog2(NUM_TIMERS + 1);

  logic          q_valid, q_pop;
  req_t          q_data;
  logic [CW-1:0] used;

  swcb_front u_front (.clk, .rst, .req, .q_valid, .q_data, .q_pop);
  swcb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .rsp, .used_out(used));

  `ASSERT_CLK(a_pop_valid, q_pop |-> q_valid, "pop from empty queue")
  `ASSERT_CLK(a_used_max, used <= CW'(NUM_TIMERS), "entry count overflow")
  `ASSERT_CLK_RST(a_rst_idle, rst |=> !rsp.valid, "result after reset")
endmodule

// ----- rtl/swcb_front.sv -----
// ----------------------------------------------------------------------------
// swcb_front
// accepts requests and holds them in a two-entry queue for the back end
// ----------------------------------------------------------------------------
module swcb_front
  import swcb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  swcb_req_if.sink   req,
  output logic       q_valid,
  output req_t       q_data,
  input  logic       q_pop
);
  req_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign req.ready = (cnt != 2'd2);
  assign q_valid   = (cnt != 2'd0);
  assign q_data    = mem[rp];

  // queue storage
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      mem[wp] <= '{op: req.operation, slot: req.slot, now: req.now_seconds,
                   cd: req.countdown, tgt: req.target_seconds};
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (req.valid && req.ready) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(req.valid && req.ready) - 2'(q_pop);
    end
  end
endmodule

// ----- rtl/swcb_back.sv -----
// ----------------------------------------------------------------------------
// swcb_back
// carries out one request at a time: entry update, shifting removal and
// the time split done as radix-16 compare and subtract of the unit lengths
// ----------------------------------------------------------------------------
module swcb_back
  import swcb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  req_t      q_data,
  output logic      q_pop,
  swcb_rsp_if.source rsp,
  output logic [$clog2(NUM_TIMERS + 1)-1:0] used_out
);
  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001, S_FETCH = 6'b000010, S_EXEC = 6'b000100,
    S_SHIFT = 6'b001000, S_SPLIT = 6'b010000, S_OUT  = 6'b100000
  } st_t;

  st_t state;
  logic [TW-1:0] start_mem [NUM_TIMERS];
  logic [TW-1:0] target_mem [NUM_TIMERS];
  logic [TW-1:0] pause_mem [NUM_TIMERS];
  logic          cd_mem [NUM_TIMERS];
  logic          act_mem [NUM_TIMERS];
  logic          pz_mem [NUM_TIMERS];
  logic [CW-1:0] used;
  req_t cur;
  logic [TW-1:0] rd_start, rd_target, rd_pause;
  logic          rd_cd, rd_act, rd_pz;
  logic [AW-1:0] idx;
  logic [CW-1:0] sh;
  logic          half;
  logic [TW-1:0] rem;
  logic [3:0]    step;
  rsp_t          res;
  logic          in_range;
  logic [AW-1:0] sl;
  logic [TW:0]   diff;
  logic          finished;
  logic [1:0]    ex_status, ex_mode;
  logic [3:0]    dig;
  logic [43:0]   sub;

  // multiple k of the unit length, weighted by the digit of split step s
  function automatic logic [43:0] step_mult(logic [3:0] s, int k);
    logic [43:0] base;
    int          sh4;
    case (s) inside
      [4'd0:4'd3]: begin base = 44'(SEC_YEAR);  sh4 = 4 * (3 - int'(s)); end
      4'd4:        begin base = 44'(SEC_MONTH); sh4 = 0; end
      4'd5:        begin base = 44'(SEC_DAY);   sh4 = 4; end
      4'd6:        begin base = 44'(SEC_DAY);   sh4 = 0; end
      4'd7:        begin base = 44'(SEC_HOUR);  sh4 = 4; end
      4'd8:        begin base = 44'(SEC_HOUR);  sh4 = 0; end
      4'd9:        begin base = 44'(60);        sh4 = 4; end
      default:     begin base = 44'(60);        sh4 = 0; end
    endcase
    return (44'(k) * base) << sh4;
  endfunction

  assign sl       = AW'(cur.slot);
  assign in_range = (int'(cur.slot) < int'(used));
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign used_out = used;

  // largest radix-16 digit whose multiple fits in the remainder
  always_comb begin
    dig = '0;
    sub = '0;
    for (int k = 1; k < 16; k++) begin
      if ({4'b0, rem} >= step_mult(step, k)) begin
        dig = 4'(k);
        sub = step_mult(step, k);
      end
    end
  end

  // signed difference for a read
  always_comb begin
    if (rd_pz)      diff = {1'b0, rd_pause} - {1'b0, rd_start};
    else if (rd_cd) diff = {1'b0, rd_target} - {1'b0, cur.now};
    else            diff = {1'b0, cur.now} - {1'b0, rd_start};
  end

  assign finished = rd_cd && (diff[TW] || diff == '0);

  // status and mode of the current request
  always_comb begin
    ex_status = ST_REJECTED;
    ex_mode   = MODE_UP;
    case (cur.op)
      OP_CREATE: if (used < CW'(NUM_TIMERS)) begin
        ex_status = ST_OK; ex_mode = cur.cd ? MODE_DOWN : MODE_UP;
      end
      OP_PAUSE: if (in_range && !rd_pz) begin
        ex_status = ST_OK; ex_mode = MODE_PAUSED;
      end
      OP_RESUME: if (in_range && rd_pz) begin
        ex_status = ST_OK; ex_mode = rd_cd ? MODE_DOWN : MODE_UP;
      end
      OP_REMOVE: if (in_range) ex_status = ST_OK;
      OP_CLEAR: ex_status = ST_OK;
      OP_READ: if (in_range) begin
        ex_mode = rd_pz ? MODE_PAUSED : (rd_cd ? MODE_DOWN : MODE_UP);
        if (!rd_act)       ex_status = ST_INACTIVE;
        else if (finished) ex_status = ST_FINISHED;
        else               ex_status = ST_OK;
      end
      default: ;
    endcase
  end

  assign rsp.valid = (state == S_OUT);
  assign {rsp.status, rsp.mode, rsp.years, rsp.months, rsp.days, rsp.hours,
          rsp.minutes, rsp.seconds} = {res.status, res.mode, res.years, res.months,
                                       res.days, res.hours, res.minutes, res.seconds};
  assign rsp.entry_count = 7'(used);

  // registered memory reads
  always_ff @(posedge clk) begin
    rd_start  <= start_mem[idx];
    rd_target <= target_mem[idx];
    rd_pause  <= pause_mem[idx];
    rd_cd     <= cd_mem[idx];
    rd_act    <= act_mem[idx];
    rd_pz     <= pz_mem[idx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; used <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_data; idx <= AW'(q_data.slot); state <= S_FETCH;
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC: begin
          res <= '{status: ex_status, mode: ex_mode, default: '0};
          if (cur.op == OP_REMOVE && in_range) state <= S_SHIFT;
          else if (cur.op == OP_READ && in_range && rd_act && !finished) state <= S_SPLIT;
          else state <= S_OUT;
          case (cur.op)
            OP_CREATE: if (used < CW'(NUM_TIMERS)) begin
              start_mem[AW'(used)]  <= cur.now;
              target_mem[AW'(used)] <= cur.cd ? cur.tgt : '0;
              pause_mem[AW'(used)]  <= '0;
              cd_mem[AW'(used)] <= cur.cd; act_mem[AW'(used)] <= 1'b1;
              pz_mem[AW'(used)] <= 1'b0;
              used <= used + 1'b1;
            end
            OP_PAUSE: if (in_range && !rd_pz) begin
              pause_mem[sl] <= cur.now; pz_mem[sl] <= 1'b1;
            end
            OP_RESUME: if (in_range && rd_pz) begin
              start_mem[sl] <= rd_start + cur.now - rd_pause; pz_mem[sl] <= 1'b0;
            end
            OP_REMOVE: if (in_range) begin
              sh <= CW'(cur.slot); idx <= AW'(CW'(cur.slot) + 1'b1); half <= 1'b0;
            end
            OP_CLEAR: used <= '0;
            OP_READ: if (in_range && rd_act) begin
              if (finished) act_mem[sl] <= 1'b0;
              else begin
                rem <= diff[TW] ? '0 : diff[TW-1:0]; step <= '0;
              end
            end
            default: ;
          endcase
        end
        // move entry sh+1 down to sh; half waits for the registered read of that entry before the write
        S_SHIFT: begin
          if (sh + 1'b1 >= used) begin
            used <= used - 1'b1; state <= S_OUT;
          end else if (half) begin
            start_mem[AW'(sh)] <= rd_start; target_mem[AW'(sh)] <= rd_target;
            pause_mem[AW'(sh)] <= rd_pause;
            cd_mem[AW'(sh)] <= rd_cd; act_mem[AW'(sh)] <= rd_act;
            pz_mem[AW'(sh)] <= rd_pz;
            sh <= sh + 1'b1; idx <= AW'(sh + 2'd2); half <= 1'b0;
          end else half <= 1'b1;
        end
        // one quotient digit per cycle, seconds last
        S_SPLIT: begin
          step <= step + 1'b1;
          case (step) inside
            4'd0:        res.years   <= {12'd0, dig};
            [4'd1:4'd3]: res.years   <= {res.years[11:0], dig};
            4'd4:        res.months  <= dig;
            4'd5:        res.days    <= {dig[0], 4'd0};
            4'd6:        res.days    <= {res.days[4], dig};
            4'd7:        res.hours   <= {dig[0], 4'd0};
            4'd8:        res.hours   <= {res.hours[4], dig};
            4'd9:        res.minutes <= {dig[1:0], 4'd0};
            4'd10:       res.minutes <= {res.minutes[5:4], dig};
            default:     res.seconds <= 6'(rem);
          endcase
          if (step == 4'd11) state <= S_OUT;
          else rem <= rem - sub[TW-1:0];
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timer bank: requests go in over the request
// channel with random gaps, a local model of the bank predicts one result per
// request, and every result is checked field by field as it comes out.
// ----------------------------------------------------------------------------
module tb_top;
  import swcb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = NUM_TIMERS_DEF;
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  swcb_req_if req ();
  swcb_rsp_if rsp ();

  stopwatch_countdown_bank dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the bank
  logic [TW-1:0] m_start [NT];
  logic [TW-1:0] m_target[NT];
  logic [TW-1:0] m_pause [NT];
  logic          m_cd    [NT];
  logic          m_active[NT];
  logic          m_paused[NT];
  int            m_used;

  rsp_t expected_q[$];
  int   errors;
  bit   no_idle;

  function automatic void clear_slot(int i);
    m_start[i] = '0;
    m_target[i] = '0;
    m_pause[i] = '0;
    m_cd[i] = 1'b0;
    m_active[i] = 1'b0;
    m_paused[i] = 1'b0;
  endfunction

  function automatic logic [1:0] slot_mode(int i);
    if (m_paused[i]) return MODE_PAUSED;
    return m_cd[i] ? MODE_DOWN : MODE_UP;
  endfunction

  // apply one request to the local bank and return its result
  function automatic rsp_t bank_apply(req_t r);
    rsp_t o;
    int s;
    bit in_range;
    longint dt;
    longint unsigned t;
    o = '0;
    o.status = ST_REJECTED;
    o.mode = MODE_UP;
    s = r.slot;
    in_range = s < m_used;
    case (r.op)
      OP_CREATE: begin
        if (m_used < NT) begin
          m_start[m_used] = r.now;
          m_target[m_used] = r.cd ? r.tgt : '0;
          m_pause[m_used] = '0;
          m_cd[m_used] = r.cd;
          m_active[m_used] = 1'b1;
          m_paused[m_used] = 1'b0;
          o.mode = slot_mode(m_used);
          m_used++;
          o.status = ST_OK;
        end
      end
      OP_PAUSE: begin
        if (in_range && !m_paused[s]) begin
          m_pause[s] = r.now;
          m_paused[s] = 1'b1;
          o.status = ST_OK;
          o.mode = slot_mode(s);
        end
      end
      OP_RESUME: begin
        if (in_range && m_paused[s]) begin
          m_start[s] = m_start[s] + r.now - m_pause[s];
          m_paused[s] = 1'b0;
          o.status = ST_OK;
          o.mode = slot_mode(s);
        end
      end
      OP_REMOVE: begin
        if (in_range) begin
          for (int i = s; i + 1 < m_used; i++) begin
            m_start[i] = m_start[i+1];
            m_target[i] = m_target[i+1];
            m_pause[i] = m_pause[i+1];
            m_cd[i] = m_cd[i+1];
            m_active[i] = m_active[i+1];
            m_paused[i] = m_paused[i+1];
          end
          m_used--;
          clear_slot(m_used);
          o.status = ST_OK;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NT; i++) clear_slot(i);
        m_used = 0;
        o.status = ST_OK;
      end
      OP_READ: begin
        if (in_range) begin
          o.mode = slot_mode(s);
          if (!m_active[s]) begin
            o.status = ST_INACTIVE;
          end else begin
            if (m_paused[s]) dt = longint'(m_pause[s]) - longint'(m_start[s]);
            else if (m_cd[s]) dt = longint'(m_target[s]) - longint'(r.now);
            else dt = longint'(r.now) - longint'(m_start[s]);
            if (m_cd[s] && dt <= 0) begin
              m_active[s] = 1'b0;
              o.status = ST_FINISHED;
            end else begin
              if (dt < 0) dt = 0;
              t = dt;
              o.years = 16'(t / SEC_YEAR);
              t = t % SEC_YEAR;
              o.months = 4'(t / SEC_MONTH);
              t = t % SEC_MONTH;
              o.days = 5'(t / SEC_DAY);
              o.hours = 5'((t / SEC_HOUR) % 24);
              o.minutes = 6'((t / 60) % 60);
              o.seconds = 6'(t % 60);
              o.status = ST_OK;
            end
          end
        end
      end
      default: ;
    endcase
    o.entry_count = 7'(m_used);
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // send one request, waiting a random gap first
  task automatic send_req(logic [2:0] op, logic [5:0] slot, logic [TW-1:0] now,
                          logic cd = 1'b0, logic [TW-1:0] tgt = '0);
    int gap;
    req_t r;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.operation <= op;
    req.slot <= slot;
    req.now_seconds <= now;
    req.countdown <= cd;
    req.target_seconds <= tgt;
    req.valid <= 1'b1;
    r = '{op: op, slot: slot, now: now, cd: cd, tgt: tgt};
    do @(posedge clk); while (!req.ready);
    expected_q.push_back(bank_apply(r));
    @(negedge clk);
  endtask

  // result side: random stalls, check against oldest prediction
  initial begin
    rsp_t w;
    int stall;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      if (expected_q.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        w = expected_q.pop_front();
        if (rsp.status !== w.status) report("status", rsp.status, w.status);
        if (rsp.mode !== w.mode) report("mode", rsp.mode, w.mode);
        if (rsp.years !== w.years) report("years", rsp.years, w.years);
        if (rsp.months !== w.months) report("months", rsp.months, w.months);
        if (rsp.days !== w.days) report("days", rsp.days, w.days);
        if (rsp.hours !== w.hours) report("hours", rsp.hours, w.hours);
        if (rsp.minutes !== w.minutes) report("minutes", rsp.minutes, w.minutes);
        if (rsp.seconds !== w.seconds) report("seconds", rsp.seconds, w.seconds);
        if (rsp.entry_count !== w.entry_count)
          report("entry_count", rsp.entry_count, w.entry_count);
      end
      @(negedge clk);
    end
  end

  // create edge values, countdown at the far end of time
  task automatic test_create;
    send_req(OP_CREATE, '0, '0);
    send_req(OP_CREATE, '0, '0, 1'b1, TMAX);
    send_req(OP_CREATE, '0, TMAX);
    send_req(OP_READ, 6'd0, TMAX);
    send_req(OP_READ, 6'd1, 40'd0);
    send_req(OP_READ, 6'd2, '0);
    send_req(OP_READ, 6'd3, '0);
  endtask

  // pause twice, resume twice, read while paused, resume an out-of-range slot
  task automatic test_pause_resume;
    send_req(OP_PAUSE, 6'd1, 40'd1000);
    send_req(OP_PAUSE, 6'd1, 40'd1001);
    send_req(OP_READ, 6'd1, 40'd5000);
    send_req(OP_RESUME, 6'd1, 40'd90061);
    send_req(OP_RESUME, 6'd1, 40'd90062);
    send_req(OP_RESUME, 6'd63, 40'd1);
  endtask

  // countdown reaching zero, then the inactive entry is read, paused and resumed
  task automatic test_finish;
    send_req(OP_CREATE, '0, 40'd100, 1'b1, 40'd50);
    send_req(OP_READ, 6'd3, 40'd100);
    send_req(OP_READ, 6'd3, 40'd100);
    send_req(OP_PAUSE, 6'd3, 40'd200);
    send_req(OP_RESUME, 6'd3, 40'd300);
  endtask

  // remove, unused codes and clear all
  task automatic test_remove_clear;
    send_req(OP_REMOVE, 6'd0, '0);
    send_req(OP_REMOVE, 6'd40, '0);
    send_req(OP_UNUSED_A, 6'd0, '0);
    send_req(OP_UNUSED_B, 6'd63, TMAX, 1'b1, TMAX);
    send_req(OP_CLEAR, '0, '0);
    send_req(OP_READ, 6'd0, '0);
  endtask

  // random batches of mostly sensible traffic around a moving time base
  task automatic test_random;
    logic [TW-1:0] base, now, tgt;
    logic [2:0] op;
    logic [5:0] slot;
    int r;
    bit fill;
    for (int b = 0; b < 12; b++) begin
      no_idle = (b % 3 == 2);
      fill = (b % 4 == 1);
      base = TW'({$urandom, $urandom});
      send_req(OP_CLEAR, 6'($urandom), base);
      for (int n = 0; n < 100; n++) begin
        base = base + TW'($urandom_range(0, 300));
        now = base;
        r = $urandom_range(0, 99);
        if (fill) op = (r < 70) ? OP_CREATE : (r < 90) ? OP_READ : OP_REMOVE;
        else if (r < 20) op = OP_CREATE;
        else if (r < 32) op = OP_PAUSE;
        else if (r < 44) op = OP_RESUME;
        else if (r < 52) op = OP_REMOVE;
        else if (r < 53) op = OP_CLEAR;
        else if (r < 98) op = OP_READ;
        else op = ($urandom_range(0, 1)) ? OP_UNUSED_A : OP_UNUSED_B;
        if (m_used > 0 && $urandom_range(0, 9) != 0) slot = 6'($urandom_range(0, m_used - 1));
        else slot = 6'($urandom);
        tgt = now + TW'($urandom_range(0, 3000));
        if ($urandom_range(0, 9) == 0)
          tgt = now + TW'({$urandom, $urandom} % 64'd40000000);
        if ($urandom_range(0, 59) == 0) begin
          now = TW'({$urandom, $urandom});
          tgt = TW'({$urandom, $urandom});
        end
        send_req(op, slot, now, 1'($urandom), tgt);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    errors = 0;
    no_idle = 1'b0;
    req.valid = 1'b0;
    req.operation = OP_CREATE;
    req.slot = '0;
    req.now_seconds = '0;
    req.countdown = 1'b0;
    req.target_seconds = '0;
    for (int i = 0; i < NT; i++) clear_slot(i);
    m_used = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_create();
    test_pause_resume();
    test_finish();
    test_remove_clear();
    test_random();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/swcb_pkg.sv
rtl/swcb_if.sv
rtl/swcb_front.sv
rtl/swcb_back.sv
rtl/stopwatch_countdown_bank.sv
verif/tb_top.sv
